@@ rtl/ecb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared types and constants of the crossover backtest core.
// ----------------------------------------------------------------------------
package ecb_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned AvgW   = 48;
  localparam int unsigned RetW   = 48;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned WeightW = 34;
  localparam int unsigned PctNumW = 56;

  localparam logic [CfgIdxW-1:0] RegBaseSpan = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepOne  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepTwo  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepThree = 2'd3;

  // 100 * 2^16
  localparam logic [23:0] PctScale = 24'd6553600;

  typedef struct packed {
    logic [PriceW-1:0] open_price;
    logic [PriceW-1:0] close_price;
    logic              first_bar;
    logic              last_bar;
  } bar_t;

  typedef struct packed {
    logic signed [RetW-1:0] cumulative_return;
    logic                   holding;
    logic                   bought_now;
    logic                   sold_now;
    logic                   series_done;
    logic                   saturated;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [PriceW-1:0] num_a;
    logic [PriceW-1:0] num_b;
    logic [PriceW-1:0] den;
  } pct_req_t;

  // Full quotient width plus sign: a percent may exceed the return range
  typedef struct packed {
    logic                      done;
    logic signed [PctNumW:0]   value;
  } pct_rsp_t;

endpackage

@@ rtl/ecb_bar_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecb_bar_fifo
// Two-entry queue of accepted bars between front and back.
// ----------------------------------------------------------------------------
module ecb_bar_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ecb_pkg::bar_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ecb_pkg::bar_t data_o
);
  ecb_pkg::bar_t mem_q [2];
  logic          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !full_o) begin
      wptr_d = ~wptr_q;
      cnt_d  = cnt_d + 2'd1;
    end
    if (pop_i && !empty_o) begin
      rptr_d = ~rptr_q;
      cnt_d  = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/ecb_pct_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecb_pct_div
// Iterative percent unit: round(|a-b| * 100 * 2^16 / den), signed by a-b.
// ----------------------------------------------------------------------------
module ecb_pct_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecb_pkg::pct_req_t req_i,
  output ecb_pkg::pct_rsp_t rsp_o
);
  localparam int unsigned NW = ecb_pkg::PctNumW;
  localparam int unsigned CW = $clog2(NW + 2);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StDone = 4'b1000
  } st_e;

  st_e                         st_q, st_d;
  logic [ecb_pkg::PriceW-1:0]  mag_q, den_q;
  logic                        neg_q;
  logic [NW-1:0]               num_q;
  logic [ecb_pkg::PriceW:0]    rem_q;
  logic [CW-1:0]               cnt_q;
  logic [ecb_pkg::PriceW+1:0]  trial;
  logic [NW:0]                 q_round;

  // Shift one numerator bit into the remainder per cycle.
  assign trial = {rem_q, num_q[NW-1]} - {2'b00, den_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (req_i.start) st_d = StMul;
      StMul:  st_d = (den_q == '0) ? StDone : StDiv;
      StDiv:  if (cnt_q == CW'(NW - 1)) st_d = StDone;
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (req_i.start) begin
          neg_q <= req_i.num_a < req_i.num_b;
          mag_q <= (req_i.num_a < req_i.num_b) ? req_i.num_b - req_i.num_a
                                               : req_i.num_a - req_i.num_b;
          den_q <= req_i.den;
        end
      end
      StMul: begin
        // Add half the divisor so the truncating quotient rounds to nearest;
        // a zero divisor gives a zero percent.
        num_q <= (den_q == '0) ? '0
               : NW'(mag_q) * NW'(ecb_pkg::PctScale) + NW'(den_q >> 1);
        rem_q <= '0;
        cnt_q <= '0;
      end
      StDiv: begin
        if (!trial[ecb_pkg::PriceW+1]) begin
          rem_q <= trial[ecb_pkg::PriceW:0];
          num_q <= {num_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[ecb_pkg::PriceW-1:0], num_q[NW-1]};
          num_q <= {num_q[NW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CW'(1);
      end
      StDone: ;
      default: ;
    endcase
  end

  assign q_round     = {1'b0, num_q};
  assign rsp_o.done  = st_q == StDone;
  assign rsp_o.value = neg_q ? -$signed(q_round) : $signed(q_round);

endmodule

@@ rtl/ecb_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecb_engine
// Back end: updates averages, detects crossings, books returns per bar.
// ----------------------------------------------------------------------------
module ecb_engine #(
  parameter int unsigned AverageCount = 4,
  parameter int unsigned MaxSpan      = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ecb_pkg::CfgW-1:0]     base_span_i,
  input  logic [ecb_pkg::CfgW-1:0]     step_one_i,
  input  logic [ecb_pkg::CfgW-1:0]     step_two_i,
  input  logic [ecb_pkg::CfgW-1:0]     step_three_i,
  input  logic                         bar_valid_i,
  input  ecb_pkg::bar_t                bar_i,
  output logic                         bar_take_o,
  output logic                         res_valid_o,
  output ecb_pkg::result_t             res_o,
  input  logic                         res_take_i
);
  localparam int unsigned KW   = $clog2(AverageCount);
  localparam int unsigned SW   = $clog2(MaxSpan + 1) + 1;
  localparam int unsigned TW   = $clog2(MaxSpan);
  localparam int unsigned AvW  = ecb_pkg::AvgW;
  localparam int unsigned RW   = ecb_pkg::RetW;
  localparam int unsigned PW   = ecb_pkg::PctNumW + 1;
  localparam int unsigned SumW = PW + 1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StStart = 9'b000000010,
    StDaily = 9'b000000100,
    StAdd   = 9'b000001000,
    StEmaW  = 9'b000010000,
    StEmaM  = 9'b000100000,
    StEmaA  = 9'b001000000,
    StFinal = 9'b010000000,
    StOut   = 9'b100000000
  } st_e;

  st_e st_q, st_d;

  logic [AvW-1:0]   avg_q [AverageCount];
  logic [AvW-1:0]   fresh_q [AverageCount];
  logic [ecb_pkg::PriceW-1:0] prev_q, entry_q;
  logic             long_q, pbuy_q, psell_q, clip_q;
  logic signed [RW-1:0] ret_q;
  ecb_pkg::bar_t    bar_q;
  logic             bought_q, sold_q;
  logic [KW-1:0]    k_q;
  logic [SW-1:0]    span_q;
  logic [ecb_pkg::WeightW-1:0] w_q;
  logic [AvW-1:0]   diff_q;
  logic             up_q;
  logic [63:0]      prod_hi_q, prod_lo_q;
  logic             res_valid_q;
  ecb_pkg::result_t res_q;

  ecb_pkg::pct_req_t pct_req;
  ecb_pkg::pct_rsp_t pct_rsp;

  ecb_pct_div u_pct (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pct_req),
    .rsp_o (pct_rsp)
  );

  logic [AvW-1:0] target;
  assign target = {bar_q.close_price, 16'd0};

  // Running span for average k; while finishing average k, look one ahead
  logic [SW+1:0] k_sel;
  logic [SW+1:0] span_raw;
  assign k_sel = (st_q == StEmaA) ? (SW+2)'(k_q) + (SW+2)'(1) : (SW+2)'(k_q);
  always_comb begin
    span_raw = (SW+2)'(base_span_i);
    if (k_sel >= (SW+2)'(1)) span_raw = span_raw + (SW+2)'(step_one_i);
    if (k_sel >= (SW+2)'(2)) span_raw = span_raw + (SW+2)'(step_two_i);
    if (k_sel >= (SW+2)'(3)) begin
      span_raw = span_raw + (SW+2)'(step_three_i) * (k_sel - (SW+2)'(2));
    end
  end

  // Weight table: entry g holds round(2^33 / (span+1)) for span g+1
  logic [ecb_pkg::WeightW-1:0] wtab [MaxSpan];
  always_ff @(posedge clk_i) begin
    w_q <= wtab[TW'(span_q - SW'(1))];
  end
  for (genvar g = 0; g < MaxSpan; g++) begin : g_wtab
    localparam longint unsigned Den = 64'(g) + 64'd2;
    localparam longint unsigned Wt  = ((64'd1 << 33) + (Den >> 1)) / Den;
    assign wtab[g] = ecb_pkg::WeightW'(Wt);
  end

  // Pick the percent operands: daily ones, or entry-to-close ones in the final step
  logic [ecb_pkg::PriceW-1:0] pa, pb, pd;
  logic do_buy, do_sell;
  assign do_buy  = pbuy_q && !long_q;
  assign do_sell = psell_q && long_q && !do_buy;
  always_comb begin
    pa = bar_q.close_price; pb = prev_q; pd = prev_q;
    if (st_q == StFinal) begin
      pa = bar_q.close_price; pb = entry_q; pd = entry_q;
    end else if (do_buy) begin
      pa = bar_q.close_price; pb = bar_q.open_price; pd = bar_q.open_price;
    end else if (do_sell) begin
      pa = bar_q.open_price; pb = prev_q; pd = prev_q;
    end
  end

  logic pct_busy_q;
  assign pct_req.start = ((st_q == StDaily) || (st_q == StFinal)) && !pct_busy_q;
  assign pct_req.num_a = pa;
  assign pct_req.num_b = pb;
  assign pct_req.den   = pd;

  // Saturating add; the sum is wide enough to hold any percent unclipped
  logic signed [SumW-1:0] sum_w;
  logic signed [PW-1:0]   add_val;
  logic signed [RW-1:0]   sat_val;
  logic                   sat_hit;
  assign sum_w = {{(SumW-RW){ret_q[RW-1]}}, ret_q} + {add_val[PW-1], add_val};
  always_comb begin
    sat_hit = !((&sum_w[SumW-1:RW-1]) || !(|sum_w[SumW-1:RW-1]));
    sat_val = sum_w[RW-1:0];
    if (sat_hit) sat_val = sum_w[SumW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
  end
  logic use_daily;
  assign use_daily = long_q || do_buy;
  assign add_val = (st_q == StFinal || use_daily) ? pct_rsp.value : '0;

  // Crossing over all pairs
  logic cross_buy, cross_sell;
  always_comb begin
    cross_buy = 1'b0; cross_sell = 1'b0;
    for (int a = 0; a < AverageCount; a++) begin
      for (int b = a + 1; b < AverageCount; b++) begin
        if (avg_q[a] < avg_q[b] && fresh_q[a] >= fresh_q[b]) cross_buy = 1'b1;
        if (avg_q[a] > avg_q[b] && fresh_q[a] <= fresh_q[b]) cross_sell = 1'b1;
      end
    end
  end

  logic [AvW-1:0] step_w;
  assign step_w = AvW'((prod_hi_q + (prod_lo_q >> 24)) >> 8);

  assign bar_take_o  = st_q == StIdle && bar_valid_i && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (bar_take_o) st_d = StStart;
      StStart: st_d = bar_q.first_bar ? StOut : StDaily;
      StDaily: if (pct_rsp.done) st_d = StEmaW;
      StAdd:   st_d = StEmaW;
      StEmaW:  st_d = StEmaM;
      StEmaM:  st_d = StEmaA;
      StEmaA:  st_d = (k_q == KW'(AverageCount - 1)) ? StAdd : StEmaW;
      StFinal: if (pct_rsp.done) st_d = StOut;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if (st_q == StAdd) st_d = (bar_q.last_bar && long_q) ? StFinal : StOut;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      res_valid_q <= 1'b0;
      long_q      <= 1'b0;
      pbuy_q      <= 1'b0;
      psell_q     <= 1'b0;
      clip_q      <= 1'b0;
      ret_q       <= '0;
      prev_q      <= '0;
      entry_q     <= '0;
      pct_busy_q  <= 1'b0;
      for (int i = 0; i < AverageCount; i++) avg_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (res_take_i && res_valid_q) res_valid_q <= 1'b0;
      if (pct_req.start) pct_busy_q <= 1'b1;
      if (pct_rsp.done) pct_busy_q <= 1'b0;
      unique case (st_q)
        StStart: begin
          if (bar_q.first_bar) begin
            ret_q <= '0; clip_q <= 1'b0; long_q <= 1'b0;
            pbuy_q <= 1'b0; psell_q <= 1'b0; entry_q <= '0;
            prev_q <= bar_q.close_price;
            for (int i = 0; i < AverageCount; i++) avg_q[i] <= target;
          end
        end
        StDaily: begin
          if (pct_rsp.done) begin
            ret_q <= sat_val;
            if (sat_hit) clip_q <= 1'b1;
            if (do_buy) begin
              entry_q <= bar_q.open_price; long_q <= 1'b1;
            end else if (do_sell) begin
              long_q <= 1'b0;
            end
          end
        end
        StAdd: begin
          pbuy_q  <= cross_buy && !bar_q.last_bar;
          psell_q <= cross_sell && !bar_q.last_bar;
          for (int i = 0; i < AverageCount; i++) avg_q[i] <= fresh_q[i];
          prev_q <= bar_q.close_price;
        end
        StFinal: begin
          if (pct_rsp.done) begin
            ret_q <= sat_val;
            if (sat_hit) clip_q <= 1'b1;
            long_q <= 1'b0;
          end
        end
        StOut: begin
          res_valid_q <= 1'b1;
          if (bar_q.last_bar) begin
            pbuy_q <= 1'b0; psell_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (bar_take_o) begin
      bar_q    <= bar_i;
      bought_q <= 1'b0;
      sold_q   <= 1'b0;
      k_q      <= '0;
    end
    if (st_q == StDaily && pct_rsp.done) begin
      bought_q <= do_buy;
      sold_q   <= do_sell;
    end
    if (st_q == StDaily || st_q == StEmaA) begin
      // Clamp span into [1, MaxSpan] ahead of the table read
      if (span_raw == '0) span_q <= SW'(1);
      else if (span_raw > (SW+2)'(MaxSpan)) span_q <= SW'(MaxSpan);
      else span_q <= SW'(span_raw);
    end
    if (st_q == StEmaW) begin
      up_q   <= target >= avg_q[k_q];
      diff_q <= (target >= avg_q[k_q]) ? target - avg_q[k_q] : avg_q[k_q] - target;
    end
    if (st_q == StEmaM) begin
      prod_hi_q <= 64'(diff_q[AvW-1:24]) * 64'(w_q);
      prod_lo_q <= 64'(diff_q[23:0]) * 64'(w_q);
    end
    if (st_q == StEmaA) begin
      fresh_q[k_q] <= up_q ? avg_q[k_q] + step_w : avg_q[k_q] - step_w;
      k_q <= k_q + KW'(1);
    end
    if (st_q == StOut) begin
      res_q.cumulative_return <= ret_q;
      res_q.holding           <= long_q;
      res_q.bought_now        <= bought_q;
      res_q.sold_now          <= sold_q;
      res_q.series_done       <= bar_q.last_bar;
      res_q.saturated         <= clip_q;
    end
  end

endmodule

@@ rtl/ema_crossover_backtest_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_crossover_backtest_core
// Long-only crossover backtest over a stream of price bars.
// ----------------------------------------------------------------------------
// Push one bar (open, close, first/last marks) per request; one result request
// follows each bar. A two-entry queue takes bars while the back end works, so
// the producer stalls only when two bars wait. Each bar runs through the shared
// bit-serial percent divider (56 quotient bits, once per bar after the first
// and again for the forced close on the last bar) plus a weight lookup,
// multiply and update for each average. Write spans only while idle; a write
// takes effect at once.
module ema_crossover_backtest_core #(
  parameter int unsigned AverageCount = 4,
  parameter int unsigned MaxSpan      = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ecb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ecb_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          push,
  input  ecb_pkg::bar_t                 bar_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output ecb_pkg::result_t              result_o
);
  logic [ecb_pkg::CfgW-1:0] base_q, s1_q, s2_q, s3_q;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ecb_pkg::CfgW'(3);
      s1_q   <= ecb_pkg::CfgW'(2);
      s2_q   <= ecb_pkg::CfgW'(2);
      s3_q   <= ecb_pkg::CfgW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecb_pkg::RegBaseSpan:  base_q <= cfg_data_i;
        ecb_pkg::RegStepOne:   s1_q   <= cfg_data_i;
        ecb_pkg::RegStepTwo:   s2_q   <= cfg_data_i;
        ecb_pkg::RegStepThree: s3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          q_empty, q_take, res_valid;
  ecb_pkg::bar_t q_bar;

  // Front: hold accepted bars
  ecb_bar_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (bar_i),
    .full_o (full),
    .pop_i  (q_take),
    .empty_o(q_empty),
    .data_o (q_bar)
  );

  // Back: run each bar to its result
  ecb_engine #(
    .AverageCount(AverageCount),
    .MaxSpan     (MaxSpan)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_span_i (base_q),
    .step_one_i  (s1_q),
    .step_two_i  (s2_q),
    .step_three_i(s3_q),
    .bar_valid_i (!q_empty),
    .bar_i       (q_bar),
    .bar_take_o  (q_take),
    .res_valid_o (res_valid),
    .res_o       (result_o),
    .res_take_i  (pop)
  );

  assign empty = !res_valid;

endmodule
